/* src/tic_pkg.sv */
package tic_pkg;

  typedef logic [6:0] char_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FRAME,
    PH_LABEL,
    PH_VALUE,
    PH_CHECK,
    PH_TAIL
  } phase_t;

  localparam int NUM_LABELS = 12;
  localparam int LABEL_ID_W = 4;
  localparam int NUM_W      = 40;
  localparam int TEXT_CHARS = 8;
  localparam int TEXT_W     = 64;
  localparam int TLEN_W     = 4;
  localparam int CFG_IDX_W  = 3;

  localparam logic [NUM_W-1:0] NUM_MAX = 40'd999999999999;
  localparam char_t CHECK_BIAS = 7'h20;
  localparam char_t DIGIT_0    = 7'h30;
  localparam char_t DIGIT_9    = 7'h39;

  localparam logic KIND_GROUP  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_END   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 3'd4;

  localparam char_t RST_FRAME_START = 7'd2;
  localparam char_t RST_FRAME_END   = 7'd3;
  localparam char_t RST_GROUP_START = 7'd10;
  localparam char_t RST_GROUP_END   = 7'd13;
  localparam char_t RST_SEPARATOR   = 7'd32;

  typedef struct packed {
    char_t frame_start;
    char_t frame_end;
    char_t group_start;
    char_t group_end;
    char_t separator;
  } cfg_t;

  typedef struct packed {
    logic                  kind;
    logic [LABEL_ID_W-1:0] label_id;
    logic [NUM_W-1:0]      numeric;
    logic [TEXT_W-1:0]     text;
    logic [TLEN_W-1:0]     text_len;
    logic                  frame_good;
  } result_t;

  // known labels, zero padded; one extra zero column acts as terminator
  localparam logic [7:0] KNOWN_CHARS [NUM_LABELS][9] = '{
    '{"A", "D", "C", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "P", "T", "A", "R", "I", "F", 8'h00, 8'h00},
    '{"I", "S", "O", "U", "S", "C", 8'h00, 8'h00, 8'h00},
    '{"B", "A", "S", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "C", "H", "C", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "C", "H", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "T", "E", "C", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "I", "N", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "M", "A", "X", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "A", "P", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "H", "P", "H", "C", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "O", "T", "D", "E", "T", "A", "T", 8'h00}
  };

  localparam logic [3:0] KNOWN_LEN [NUM_LABELS] = '{
    4'd4, 4'd7, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8
  };

endpackage

/* src/tic_label_match.sv */
module tic_label_match #(
  parameter int LABEL_CHARS = 8
) (
  input  logic [LABEL_CHARS*7-1:0]          label_flat,
  output logic                              hit,
  output logic [tic_pkg::LABEL_ID_W-1:0]    id
);

  // compare through the terminator position when the label buffer reaches it
  localparam int CMP = (LABEL_CHARS > 8) ? 9 : 8;

  logic [tic_pkg::NUM_LABELS-1:0] same;

  always_comb begin
    for (int k = 0; k < tic_pkg::NUM_LABELS; k++) begin
      same[k] = 1'b1;
      for (int i = 0; i < CMP; i++) begin
        if (4'(i) <= tic_pkg::KNOWN_LEN[k] &&
            {1'b0, label_flat[i*7 +: 7]} != tic_pkg::KNOWN_CHARS[k][i]) begin
          same[k] = 1'b0;
        end
      end
    end
  end

  // lowest label index wins
  always_comb begin
    hit = 1'b0;
    id  = '0;
    for (int k = 0; k < tic_pkg::NUM_LABELS; k++) begin
      if (!hit && same[k]) begin
        hit = 1'b1;
        id  = tic_pkg::LABEL_ID_W'(k);
      end
    end
  end

endmodule

/* src/tic_core.sv */
module tic_core #(
  parameter int LABEL_CHARS = 8,
  parameter int VALUE_MAX   = 19,
  parameter int GROUP_MAX   = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  tic_pkg::char_t    rx_char,
  input  tic_pkg::cfg_t     cfg,
  output logic              res_vld,
  output tic_pkg::result_t  res
);

  localparam int LL_W  = $clog2(LABEL_CHARS + 2);
  localparam int VL_W  = $clog2(VALUE_MAX + 2);
  localparam int CNT_W = $clog2(GROUP_MAX + 1);

  tic_pkg::phase_t phase, phase_next;

  logic [5:0]                  running_sum, running_sum_next;
  tic_pkg::char_t              label_chars [LABEL_CHARS];
  tic_pkg::char_t              label_chars_next [LABEL_CHARS];
  logic [LL_W-1:0]             label_len, label_len_next;
  logic [tic_pkg::NUM_W-1:0]   value_num, value_num_next;
  logic                        digits_ok, digits_ok_next;
  logic [tic_pkg::TEXT_W-1:0]  value_text, value_text_next;
  logic [VL_W-1:0]             value_len, value_len_next;
  tic_pkg::char_t              check_char, check_char_next;
  logic [1:0]                  sep_count, sep_count_next;
  logic [CNT_W-1:0]            start_count, start_count_next;
  logic [CNT_W-1:0]            end_count, end_count_next;

  logic is_fs, is_fe, is_gs, is_ge, is_sep, is_digit;
  logic [LABEL_CHARS*7-1:0] label_flat;
  logic label_hit;
  logic [tic_pkg::LABEL_ID_W-1:0] label_id;
  logic [tic_pkg::NUM_W+3:0] num_scaled;
  logic group_good;

  // control characters, first match wins
  always_comb begin
    is_fs  = (rx_char == cfg.frame_start);
    is_fe  = !is_fs && (rx_char == cfg.frame_end);
    is_gs  = !is_fs && !is_fe && (rx_char == cfg.group_start);
    is_ge  = !is_fs && !is_fe && !is_gs && (rx_char == cfg.group_end);
    is_sep = !is_fs && !is_fe && !is_gs && !is_ge && (rx_char == cfg.separator);
    is_digit = (rx_char >= tic_pkg::DIGIT_0) && (rx_char <= tic_pkg::DIGIT_9);
  end

  always_comb begin
    for (int i = 0; i < LABEL_CHARS; i++) begin
      label_flat[i*7 +: 7] = label_chars[i];
    end
  end

  tic_label_match #(
    .LABEL_CHARS (LABEL_CHARS)
  ) u_match (
    .label_flat (label_flat),
    .hit        (label_hit),
    .id         (label_id)
  );

  always_comb begin
    group_good = (phase == tic_pkg::PH_TAIL) && (sep_count >= 2'd2) &&
                 (label_len != '0) && (label_len <= LL_W'(LABEL_CHARS)) &&
                 (value_len <= VL_W'(VALUE_MAX)) &&
                 (({1'b0, running_sum} + tic_pkg::CHECK_BIAS) == check_char) &&
                 label_hit;
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (is_fs) begin
      phase_next = tic_pkg::PH_FRAME;
    end else if (phase != tic_pkg::PH_IDLE) begin
      if (is_fe) begin
        phase_next = tic_pkg::PH_IDLE;
      end else if (is_gs) begin
        phase_next = tic_pkg::PH_LABEL;
      end else if (is_ge) begin
        phase_next = tic_pkg::PH_FRAME;
      end else begin
        case (phase)
          tic_pkg::PH_LABEL: if (is_sep) phase_next = tic_pkg::PH_VALUE;
          tic_pkg::PH_VALUE: if (is_sep) phase_next = tic_pkg::PH_CHECK;
          tic_pkg::PH_CHECK: phase_next = tic_pkg::PH_TAIL;
          default:           phase_next = phase;
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_vld = 1'b0;
    res     = '0;
    if (!is_fs && phase != tic_pkg::PH_IDLE) begin
      if (is_fe) begin
        res_vld        = 1'b1;
        res.kind       = tic_pkg::KIND_STATUS;
        res.frame_good = (start_count != '0) && (start_count == end_count);
      end else if (is_ge && group_good) begin
        res_vld      = 1'b1;
        res.kind     = tic_pkg::KIND_GROUP;
        res.label_id = label_id;
        res.numeric  = value_num;
        res.text     = value_text;
        res.text_len = (value_len < VL_W'(tic_pkg::TEXT_CHARS)) ?
                       tic_pkg::TLEN_W'(value_len) : tic_pkg::TLEN_W'(tic_pkg::TEXT_CHARS);
      end
    end
  end

  // group fields and counts
  always_comb begin
    running_sum_next = running_sum;
    label_chars_next = label_chars;
    label_len_next   = label_len;
    value_num_next   = value_num;
    digits_ok_next   = digits_ok;
    value_text_next  = value_text;
    value_len_next   = value_len;
    check_char_next  = check_char;
    sep_count_next   = sep_count;
    start_count_next = start_count;
    end_count_next   = end_count;
    num_scaled = ({4'b0, value_num} << 3) + ({4'b0, value_num} << 1) +
                 (tic_pkg::NUM_W+4)'(rx_char - tic_pkg::DIGIT_0);

    if (is_fs || (phase != tic_pkg::PH_IDLE && (is_fe || is_gs))) begin
      running_sum_next = '0;
      for (int i = 0; i < LABEL_CHARS; i++) label_chars_next[i] = '0;
      label_len_next   = '0;
      value_num_next   = '0;
      digits_ok_next   = 1'b1;
      value_text_next  = '0;
      value_len_next   = '0;
      check_char_next  = '0;
      sep_count_next   = '0;
      if (is_fs) begin
        start_count_next = '0;
        end_count_next   = '0;
      end else if (is_gs && start_count < CNT_W'(GROUP_MAX)) begin
        start_count_next = start_count + 1'b1;
      end
    end else if (phase != tic_pkg::PH_IDLE && is_ge) begin
      if (end_count < CNT_W'(GROUP_MAX)) end_count_next = end_count + 1'b1;
    end else begin
      case (phase)
        tic_pkg::PH_LABEL: begin
          running_sum_next = running_sum + rx_char[5:0];
          if (is_sep) begin
            sep_count_next = 2'd1;
          end else if (label_len < LL_W'(LABEL_CHARS)) begin
            for (int i = 0; i < LABEL_CHARS; i++) begin
              if (label_len == LL_W'(i)) label_chars_next[i] = rx_char;
            end
            label_len_next = label_len + 1'b1;
          end else begin
            label_len_next = LL_W'(LABEL_CHARS + 1);
          end
        end
        tic_pkg::PH_VALUE: begin
          if (is_sep) begin
            sep_count_next = 2'd2;
          end else begin
            running_sum_next = running_sum + rx_char[5:0];
            if (value_len >= VL_W'(VALUE_MAX)) begin
              value_len_next = VL_W'(VALUE_MAX + 1);
            end else begin
              // first character lands in the top byte
              for (int b = 0; b < tic_pkg::TEXT_CHARS; b++) begin
                if (value_len == VL_W'(tic_pkg::TEXT_CHARS - 1 - b)) begin
                  value_text_next[b*8 +: 8] = {1'b0, rx_char};
                end
              end
              value_len_next = value_len + 1'b1;
              if (digits_ok && is_digit) begin
                if (num_scaled > {4'b0, tic_pkg::NUM_MAX}) begin
                  value_num_next = tic_pkg::NUM_MAX;
                end else begin
                  value_num_next = num_scaled[tic_pkg::NUM_W-1:0];
                end
              end else begin
                digits_ok_next = 1'b0;
              end
            end
          end
        end
        tic_pkg::PH_CHECK: check_char_next = rx_char;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tic_pkg::PH_IDLE;
      running_sum <= '0;
      for (int i = 0; i < LABEL_CHARS; i++) label_chars[i] <= '0;
      label_len   <= '0;
      value_num   <= '0;
      digits_ok   <= 1'b1;
      value_text  <= '0;
      value_len   <= '0;
      check_char  <= '0;
      sep_count   <= '0;
      start_count <= '0;
      end_count   <= '0;
    end else if (go) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      label_chars <= label_chars_next;
      label_len   <= label_len_next;
      value_num   <= value_num_next;
      digits_ok   <= digits_ok_next;
      value_text  <= value_text_next;
      value_len   <= value_len_next;
      check_char  <= check_char_next;
      sep_count   <= sep_count_next;
      start_count <= start_count_next;
      end_count   <= end_count_next;
    end
  end

endmodule

/* src/meter_teleinfo_frame_decoder.sv */
// Teleinformation frame decoder: takes one 7-bit received character per transfer on the
// slave stream and parses frames, groups, labels, values and checksums. A result leaves on
// the master stream for every well-formed group with a good checksum, a known label and a
// value within VALUE_MAX characters (tuser low), and for every frame end inside a frame
// (tuser high, status in frame_good). A character is taken every cycle unless the output
// register stalls, which alone holds the flow; the single-pass parse step lies between
// the input and the output register, which offers the result. Control characters are
// set by the write port and should be changed only while no character is in flight.
module meter_teleinfo_frame_decoder #(
  parameter int LABEL_CHARS = 8,
  parameter int VALUE_MAX   = 19,
  parameter int GROUP_MAX   = 63
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // rx_char[6:0], zero bit
  output logic          m_tvalid,
  input  logic          m_tready,
  // label_id[3:0], numeric_value[43:4], text_value[107:44], text_length[111:108],
  // frame_good[112], zeros
  output logic [119:0]  m_tdata,
  output logic          m_tuser,   // result_kind
  input  logic          cfg_wen,
  input  logic [2:0]    cfg_index,
  input  logic [6:0]    cfg_data
);

  tic_pkg::cfg_t    cfg;
  tic_pkg::char_t   in_char;
  logic             in_vld;
  logic             go;
  logic             res_vld;
  tic_pkg::result_t res;
  tic_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_start <= tic_pkg::RST_FRAME_START;
      cfg.frame_end   <= tic_pkg::RST_FRAME_END;
      cfg.group_start <= tic_pkg::RST_GROUP_START;
      cfg.group_end   <= tic_pkg::RST_GROUP_END;
      cfg.separator   <= tic_pkg::RST_SEPARATOR;
    end else if (cfg_wen) begin
      case (cfg_index)
        tic_pkg::REG_FRAME_START: cfg.frame_start <= cfg_data;
        tic_pkg::REG_FRAME_END:   cfg.frame_end   <= cfg_data;
        tic_pkg::REG_GROUP_START: cfg.group_start <= cfg_data;
        tic_pkg::REG_GROUP_END:   cfg.group_end   <= cfg_data;
        tic_pkg::REG_SEPARATOR:   cfg.separator   <= cfg_data;
        default: ;
      endcase
    end
  end

  // parse step runs when the output register is free or being emptied
  assign go       = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (go) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_char <= s_tdata[6:0];
  end

  tic_core #(
    .LABEL_CHARS (LABEL_CHARS),
    .VALUE_MAX   (VALUE_MAX),
    .GROUP_MAX   (GROUP_MAX)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .rx_char (in_char),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && res_vld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_vld) out_res <= res;
  end

  assign m_tdata = {7'b0, out_res.frame_good, out_res.text_len, out_res.text,
                    out_res.numeric, out_res.label_id};
  assign m_tuser = out_res.kind;

endmodule
